/* design/cslm_pkg.sv */
// Shared types and constants of the critical section latency monitor.
`timescale 1ns / 1ps

package cslm_pkg;

  localparam int NUM_CPUS    = 4;
  localparam int NUM_CLASSES = 3;
  localparam int ENTRIES     = NUM_CPUS * NUM_CLASSES;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CALIB_W     = 16;

  typedef enum logic [1:0] {
    REQ_DISABLE = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CLASS_IRQ     = 2'd0,
    CLASS_SOFTIRQ = 2'd1,
    CLASS_PREEMPT = 2'd2
  } class_t;

  typedef enum logic {
    REG_CALIBRATION = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] start_time;
    logic [63:0] start_address;
    logic [63:0] longest;
    logic [63:0] shortest;
    logic [63:0] sum_of_lengths;
    logic [31:0] enable_tally;
    logic [63:0] longest_start_address;
    logic [63:0] longest_end_address;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    start_time:            64'd0,
    start_address:         64'd0,
    longest:               64'd0,
    shortest:              '1,
    sum_of_lengths:        64'd0,
    enable_tally:          32'd0,
    longest_start_address: 64'd0,
    longest_end_address:   64'd0
  };

endpackage

/* design/cslm_if.sv */
// Handshake channels for the event input and the statistics output.
`timescale 1ns / 1ps

interface cslm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  cpu_index;
  logic [1:0]  section_class;
  logic [63:0] timestamp;
  logic [63:0] code_address;

  modport source (output valid, req_type, cpu_index, section_class, timestamp,
                  code_address, input ready);
  modport sink (input valid, req_type, cpu_index, section_class, timestamp,
                code_address, output ready);
endinterface

interface cslm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] least_latency;
  logic [63:0] peak_latency;
  logic [63:0] latency_total;
  logic [31:0] sample_count;
  logic [63:0] worst_disable_address;
  logic [63:0] worst_enable_address;
  logic        no_samples;

  modport source (output valid, least_latency, peak_latency, latency_total, sample_count,
                  worst_disable_address, worst_enable_address, no_samples,
                  input ready);
  modport sink (input valid, least_latency, peak_latency, latency_total, sample_count,
                worst_disable_address, worst_enable_address, no_samples,
                output ready);
endinterface

/* design/critical_section_latency_monitor.sv */
// Top level of the critical section latency monitor.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Carries
//  in_ch     in         valid/ready          request, cpu, class, timestamp, address
//  out_ch    out        valid/ready          statistics of one entry (read requests)
//  APB       in/out     psel/penable/pready  calibration offset (register 0)
//
// Each item passes through S_IDLE, where it is accepted and the entry memory is
// read, S_CALC for the subtraction, and S_UPD for the update and write-back; the
// block takes a new item only in S_IDLE, so never before the last is through.
// Reset (synchronous, rst_n low) clears the per-entry valid bits, so every entry
// reads as its reset value at once; no clearing pass is needed.
// A read request whose result cannot be loaded because the output register is
// still full waits in the update cycle until the output side takes its item.

module critical_section_latency_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  cslm_in_if.sink                          in_ch,
  cslm_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cslm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cslm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cslm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_UPD
  } state_t;

  state_t state_r;

  // Configuration register.
  logic [cslm_pkg::CALIB_W-1:0] calib_r;
  cslm_pkg::reg_idx_t           cfg_idx;

  // Entry memory and its valid bits. An entry whose valid bit is clear holds
  // stale data and is read as the reset value instead.
  cslm_pkg::entry_t             mem [cslm_pkg::ENTRIES];
  logic [cslm_pkg::ENTRIES-1:0] vld_r;
  cslm_pkg::entry_t             rd_r;
  logic                         ev_r;

  // Request held while it is worked on.
  cslm_pkg::req_t               req_r;
  logic                         irq_r;
  logic                         hit_r;
  logic [cslm_pkg::IDX_W-1:0]   idx_r;
  logic [63:0]                  ts_r;
  logic [63:0]                  addr_r;

  // Values carried from the subtraction cycle to the update cycle.
  cslm_pkg::entry_t             cur_r;
  logic [63:0]                  diff_r;

  // Output register.
  logic                         out_valid_r;
  logic [63:0]                  min_r;
  logic [63:0]                  max_r;
  logic [63:0]                  total_r;
  logic [31:0]                  count_r;
  logic [63:0]                  wdis_r;
  logic [63:0]                  wen_r;
  logic                         none_r;

  logic                         in_fire;
  logic                         in_hit;
  logic [cslm_pkg::IDX_W-1:0]   in_idx;
  cslm_pkg::entry_t             cur;
  cslm_pkg::entry_t             upd;
  logic                         mem_we;
  logic                         out_busy;
  logic                         out_load;
  logic [63:0]                  calib_ext;

  // ------------------------------------------------------------------------
  // Configuration port. Only bit 2 of the byte address selects a register.
  // ------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = cslm_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      cslm_pkg::REG_CALIBRATION: prdata = {{(cslm_pkg::CFG_DATA_W-cslm_pkg::CALIB_W){1'b0}},
                                           calib_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 cfg_idx == cslm_pkg::REG_CALIBRATION) begin
      calib_r <= pwdata[cslm_pkg::CALIB_W-1:0];
    end
  end

  assign calib_ext = {{(64-cslm_pkg::CALIB_W){1'b0}}, calib_r};

  // ------------------------------------------------------------------------
  // Entry selection at the input. Out-of-range entries address entry 0 but
  // are never written and read back as having no samples.
  // ------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_hit      = (32'(in_ch.cpu_index) < cslm_pkg::NUM_CPUS) &&
                       (32'(in_ch.section_class) < cslm_pkg::NUM_CLASSES);
  assign in_idx      = in_hit ? cslm_pkg::IDX_W'(32'(in_ch.cpu_index) * cslm_pkg::NUM_CLASSES
                                                 + 32'(in_ch.section_class))
                              : '0;

  // Entry as it stands, with a cleared entry shown at its reset value.
  assign cur = ev_r ? rd_r : cslm_pkg::ENTRY_RESET;

  // ------------------------------------------------------------------------
  // New value of the entry, formed in the update cycle.
  // ------------------------------------------------------------------------
  always_comb begin
    upd    = cur_r;
    mem_we = 1'b0;
    if (state_r == S_UPD && hit_r) begin
      unique case (req_r)
        cslm_pkg::REQ_DISABLE: begin
          upd.start_time    = ts_r;
          upd.start_address = addr_r;
          mem_we            = 1'b1;
        end
        cslm_pkg::REQ_ENABLE: begin
          // An interrupt section with no recorded start is not measured.
          if (!(irq_r && cur_r.start_time == 64'd0)) begin
            if (diff_r > cur_r.longest) begin
              upd.longest               = diff_r;
              upd.longest_end_address   = addr_r;
              upd.longest_start_address = cur_r.start_address;
            end
            if (diff_r < cur_r.shortest) begin
              upd.shortest = diff_r;
            end
            upd.sum_of_lengths = cur_r.sum_of_lengths + diff_r;
            if (cur_r.enable_tally != '1) begin
              upd.enable_tally = cur_r.enable_tally + 32'd1;
            end
            mem_we = 1'b1;
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Entry memory: one read at acceptance, one write in the update cycle.
  // Items are handled one at a time, so a read never overlaps a pending
  // write to the same entry.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= upd;
    end
    if (in_fire) begin
      rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (state_r == S_UPD && req_r == cslm_pkg::REQ_CLEAR) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Sequencer, request registers and output register.
  // ------------------------------------------------------------------------
  assign out_busy = out_valid_r && !out_ch.ready;
  assign out_load = (state_r == S_UPD) && (req_r == cslm_pkg::REQ_READ) && !out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A new result may replace the one taken at this very edge.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r   <= cslm_pkg::req_t'(in_ch.req_type);
            irq_r   <= (in_ch.section_class == cslm_pkg::CLASS_IRQ);
            hit_r   <= in_hit;
            idx_r   <= in_idx;
            ts_r    <= in_ch.timestamp;
            addr_r  <= in_ch.code_address;
            ev_r    <= vld_r[in_idx];
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          cur_r   <= cur;
          diff_r  <= ts_r - cur.start_time;
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (req_r == cslm_pkg::REQ_READ) begin
            if (!out_busy) begin
              if (!hit_r || cur_r.enable_tally == 32'd0) begin
                min_r   <= 64'd0;
                max_r   <= 64'd0;
                total_r <= 64'd0;
                count_r <= 32'd0;
                wdis_r  <= 64'd0;
                wen_r   <= 64'd0;
                none_r  <= 1'b1;
              end else begin
                min_r   <= cur_r.shortest + calib_ext;
                max_r   <= cur_r.longest + calib_ext;
                total_r <= cur_r.sum_of_lengths;
                count_r <= cur_r.enable_tally;
                wdis_r  <= cur_r.longest_start_address;
                wen_r   <= cur_r.longest_end_address;
                none_r  <= 1'b0;
              end
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.least_latency         = min_r;
  assign out_ch.peak_latency          = max_r;
  assign out_ch.latency_total         = total_r;
  assign out_ch.sample_count          = count_r;
  assign out_ch.worst_disable_address = wdis_r;
  assign out_ch.worst_enable_address  = wen_r;
  assign out_ch.no_samples            = none_r;

endmodule

/* tb/sv/critical_section_latency_monitor_test.sv */
// Self-checking testbench: directed and random trace events checked against an in-bench predictor.
`timescale 1ns / 1ps

module critical_section_latency_monitor_test;

  localparam int IDLE_PCT      = 36;      // chance in a hundred that a side idles in a cycle
  localparam int HOLD_CYCLES   = 400;     // long output hold-off in the pressure phase
  localparam int SETTLE_CYCLES = 12;      // settling time after the last owed result
  localparam int LIMIT_NS      = 800_000; // timeout, far beyond the slowest correct run
  localparam int PRINT_CAP     = 40;

  // One trace event as offered on the input channel. The class is kept as raw bits so
  // that the unused encoding can be sent as well.
  typedef struct packed {
    cslm_pkg::req_t req;
    logic [1:0]     cpu;
    logic [1:0]     cls;
    logic [63:0]    ts;
    logic [63:0]    pc;
  } sec_event_t;

  // Statistics of one entry as returned for a read request.
  typedef struct packed {
    logic [63:0] min_lat;
    logic [63:0] max_lat;
    logic [63:0] total;
    logic [31:0] count;
    logic [63:0] worst_open_pc;
    logic [63:0] worst_close_pc;
    logic        empty;
  } sec_stats_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [cslm_pkg::CFG_ADDR_W-1:0] paddr;
  logic [cslm_pkg::CFG_DATA_W-1:0] pwdata;
  logic [cslm_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  cslm_in_if  in_ch ();
  cslm_out_if out_ch ();

  critical_section_latency_monitor i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Predictor state: one copy of every per-entry statistic, plus the offset register.
  logic [63:0]                  start_ts      [cslm_pkg::ENTRIES];
  logic [63:0]                  start_pc      [cslm_pkg::ENTRIES];
  logic [63:0]                  peak_len      [cslm_pkg::ENTRIES];
  logic [63:0]                  least_len     [cslm_pkg::ENTRIES];
  logic [63:0]                  len_sum       [cslm_pkg::ENTRIES];
  logic [31:0]                  tally         [cslm_pkg::ENTRIES];
  logic [63:0]                  peak_open_pc  [cslm_pkg::ENTRIES];
  logic [63:0]                  peak_close_pc [cslm_pkg::ENTRIES];
  logic [cslm_pkg::CALIB_W-1:0] calib_now;

  sec_event_t trace_q[$];   // events still to be offered by the driver
  sec_stats_t stats_due[$]; // statistics the block still owes, oldest first

  sec_event_t nxt;
  sec_event_t seen;
  sec_stats_t want;
  bit         in_took;
  bit         calm;         // both sides run without idling while this is set
  int         phase;
  int         hold_left;
  bit         hold_done;
  int         errors;
  int         n_items;
  int         n_reads;
  int         n_measured;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, exp_val);
  endtask

  task automatic wipe_entries();
    for (int e = 0; e < cslm_pkg::ENTRIES; e++) begin
      start_ts[e]      = '0;
      start_pc[e]      = '0;
      peak_len[e]      = '0;
      least_len[e]     = '1;
      len_sum[e]       = '0;
      tally[e]         = '0;
      peak_open_pc[e]  = '0;
      peak_close_pc[e] = '0;
    end
  endtask

  // Applies one accepted event to the predictor and queues the statistics a read owes.
  task automatic account_trace(input sec_event_t ev);
    bit          hit;
    int          e;
    logic [63:0] span;
    sec_stats_t  res;
    hit = (ev.cpu < cslm_pkg::NUM_CPUS) && (ev.cls < cslm_pkg::NUM_CLASSES);
    e   = hit ? ev.cpu * cslm_pkg::NUM_CLASSES + ev.cls : 0;
    case (ev.req)
      cslm_pkg::REQ_DISABLE: begin
        if (hit) begin
          start_ts[e] = ev.ts;
          start_pc[e] = ev.pc;
        end
      end
      cslm_pkg::REQ_ENABLE: begin
        // An interrupt section that never recorded a start is not measured.
        if (hit && !(ev.cls == cslm_pkg::CLASS_IRQ && start_ts[e] == 64'd0)) begin
          span = ev.ts - start_ts[e];
          // A tie with the current longest keeps the earlier addresses.
          if (span > peak_len[e]) begin
            peak_len[e]      = span;
            peak_close_pc[e] = ev.pc;
            peak_open_pc[e]  = start_pc[e];
          end
          if (span < least_len[e])
            least_len[e] = span;
          len_sum[e] = len_sum[e] + span;
          if (tally[e] != '1)
            tally[e] = tally[e] + 32'd1;
          n_measured++;
        end
      end
      cslm_pkg::REQ_CLEAR: begin
        wipe_entries();
      end
      default: begin
        res = '0;
        res.empty = 1'b1;
        if (hit && tally[e] != 32'd0) begin
          res.min_lat        = least_len[e] + 64'(calib_now);
          res.max_lat        = peak_len[e] + 64'(calib_now);
          res.total          = len_sum[e];
          res.count          = tally[e];
          res.worst_open_pc  = peak_open_pc[e];
          res.worst_close_pc = peak_close_pc[e];
          res.empty          = 1'b0;
        end
        stats_due.push_back(res);
      end
    endcase
  endtask

  task automatic push_trace(input cslm_pkg::req_t req, input logic [1:0] cpu,
                            input logic [1:0] cls, input logic [63:0] ts,
                            input logic [63:0] pc);
    sec_event_t ev;
    ev.req = req;
    ev.cpu = cpu;
    ev.cls = cls;
    ev.ts  = ts;
    ev.pc  = pc;
    trace_q.push_back(ev);
  endtask

  // Most of the random traffic is disable/enable pairs on one entry, often followed by a
  // read of that entry; the rest is stray reads, noise on every field and the odd clear.
  task automatic add_random_traces(input int unsigned n);
    int unsigned added;
    int unsigned pick;
    logic [1:0]  cpu;
    logic [1:0]  cls;
    logic [63:0] t0;
    logic [63:0] span;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      cpu  = 2'($urandom_range(3));
      cls  = 2'($urandom_range(2));
      if (pick < 60) begin
        t0   = ($urandom_range(9) == 0) ? 64'd0 : rand64();
        span = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(5000));
        push_trace(cslm_pkg::REQ_DISABLE, cpu, cls, t0, rand64());
        push_trace(cslm_pkg::REQ_ENABLE, cpu, cls, t0 + span, rand64());
        added += 2;
        // A second enable against the same start, half the time an exact tie.
        if ($urandom_range(3) == 0) begin
          push_trace(cslm_pkg::REQ_ENABLE, cpu, cls,
                     t0 + ($urandom_range(1) ? span : 64'($urandom_range(8000))), rand64());
          added++;
        end
        if ($urandom_range(1)) begin
          push_trace(cslm_pkg::REQ_READ, cpu, cls, rand64(), rand64());
          added++;
        end
      end else if (pick < 85) begin
        push_trace(cslm_pkg::REQ_READ, cpu, 2'($urandom_range(3)), rand64(), rand64());
        added++;
      end else if (pick < 98) begin
        push_trace(cslm_pkg::req_t'(2'($urandom_range(3))), cpu, 2'($urandom_range(3)),
                   rand64(), rand64());
        added++;
      end else begin
        push_trace(cslm_pkg::REQ_CLEAR, cpu, cls, rand64(), rand64());
        added++;
      end
    end
  endtask

  task automatic apb_write(input logic [cslm_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [cslm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (addr[cslm_pkg::CFG_ADDR_W-1:2] == cslm_pkg::REG_CALIBRATION)
      calib_now = data[cslm_pkg::CALIB_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads the offset register back and compares it with the predictor's copy.
  task automatic apb_check_offset();
    logic [cslm_pkg::CFG_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {cslm_pkg::REG_CALIBRATION, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    if (got !== cslm_pkg::CFG_DATA_W'(calib_now))
      report_mismatch("calibration offset read back", 64'(got), 64'(calib_now));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every queued event is accepted and every owed result has come back, then
  // waits SETTLE_CYCLES more so that trailing updates finish before the next write.
  task automatic settle();
    do @(posedge clk);
    while (trace_q.size() != 0 || in_ch.valid || stats_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender. It holds an offered item until the block takes it, otherwise it idles at random
  // or offers the next queued event.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (trace_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = trace_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= nxt.req;
        in_ch.cpu_index     <= nxt.cpu;
        in_ch.section_class <= nxt.cls;
        in_ch.timestamp     <= nxt.ts;
        in_ch.code_address  <= nxt.pc;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver. In the pressure phase it refuses results for a long stretch, so the block
  // fills up and must push back on its input; in the calm phase it never refuses.
  always @(negedge clk) begin
    if (rst_n && phase == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor. Accepted events feed the predictor; accepted results are checked, field by
  // field, against the oldest owed statistics.
  always @(posedge clk) begin
    in_took = rst_n && in_ch.valid && in_ch.ready;
    if (in_took) begin
      seen.req = cslm_pkg::req_t'(in_ch.req_type);
      seen.cpu = in_ch.cpu_index;
      seen.cls = in_ch.section_class;
      seen.ts  = in_ch.timestamp;
      seen.pc  = in_ch.code_address;
      account_trace(seen);
      n_items++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (stats_due.size() == 0) begin
        report_mismatch("result with nothing owed, peak_latency", out_ch.peak_latency, '0);
      end else begin
        want = stats_due.pop_front();
        n_reads++;
        if (out_ch.least_latency !== want.min_lat)
          report_mismatch("least_latency", out_ch.least_latency, want.min_lat);
        if (out_ch.peak_latency !== want.max_lat)
          report_mismatch("peak_latency", out_ch.peak_latency, want.max_lat);
        if (out_ch.latency_total !== want.total)
          report_mismatch("latency_total", out_ch.latency_total, want.total);
        if (out_ch.sample_count !== want.count)
          report_mismatch("sample_count", 64'(out_ch.sample_count), 64'(want.count));
        if (out_ch.worst_disable_address !== want.worst_open_pc)
          report_mismatch("worst_disable_address", out_ch.worst_disable_address,
                          want.worst_open_pc);
        if (out_ch.worst_enable_address !== want.worst_close_pc)
          report_mismatch("worst_enable_address", out_ch.worst_enable_address,
                          want.worst_close_pc);
        if (out_ch.no_samples !== want.empty)
          report_mismatch("no_samples", 64'(out_ch.no_samples), 64'(want.empty));
      end
    end
  end

  // Main sequence: reset, then four phases, each opened by register writes while the
  // block is idle and closed by draining every owed result.
  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = cslm_pkg::REQ_READ;
    in_ch.cpu_index     = '0;
    in_ch.section_class = cslm_pkg::CLASS_IRQ;
    in_ch.timestamp     = '0;
    in_ch.code_address  = '0;
    out_ch.ready        = 1'b0;
    calm                = 1'b0;
    phase               = 0;
    hold_left           = 0;
    hold_done           = 1'b0;
    errors              = 0;
    n_items             = 0;
    n_reads             = 0;
    n_measured          = 0;
    calib_now           = '0;
    wipe_entries();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed phase with the largest offset, so that a maximal latency wraps on report.
    apb_check_offset();
    apb_write({cslm_pkg::REG_CALIBRATION, 2'b00}, cslm_pkg::CFG_DATA_W'(16'hFFFF));
    apb_check_offset();
    // An entry never used, then an interrupt enable with no start.
    push_trace(cslm_pkg::REQ_READ,    2'd0, cslm_pkg::CLASS_IRQ,     64'd0, 64'd0);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd0, cslm_pkg::CLASS_IRQ,     64'd500, 64'd1);
    push_trace(cslm_pkg::REQ_READ,    2'd0, cslm_pkg::CLASS_IRQ,     '1, '1);
    // A softirq section counts from a start of zero.
    push_trace(cslm_pkg::REQ_ENABLE,  2'd1, cslm_pkg::CLASS_SOFTIRQ, '1, 64'hDEAD_BEEF);
    push_trace(cslm_pkg::REQ_READ,    2'd1, cslm_pkg::CLASS_SOFTIRQ, 64'd0, 64'd0);
    // A section, then a tie, then a shorter one.
    push_trace(cslm_pkg::REQ_DISABLE, 2'd0, cslm_pkg::CLASS_IRQ,     64'd100, '1);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd0, cslm_pkg::CLASS_IRQ,     64'd150,
               64'hAAAA_AAAA_AAAA_AAAA);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd0, cslm_pkg::CLASS_IRQ,     64'd150,
               64'h5555_5555_5555_5555);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd0, cslm_pkg::CLASS_IRQ,     64'd120, 64'd0);
    push_trace(cslm_pkg::REQ_READ,    2'd0, cslm_pkg::CLASS_IRQ,     64'd0, 64'd0);
    // The counter wraps between disable and enable; then a section of zero length.
    push_trace(cslm_pkg::REQ_DISABLE, 2'd3, cslm_pkg::CLASS_PREEMPT,
               64'hFFFF_FFFF_FFFF_FFF0, 64'd0);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd3, cslm_pkg::CLASS_PREEMPT, 64'd5, '1);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd3, cslm_pkg::CLASS_PREEMPT,
               64'hFFFF_FFFF_FFFF_FFF0, 64'd7);
    push_trace(cslm_pkg::REQ_READ,    2'd3, cslm_pkg::CLASS_PREEMPT, 64'd0, 64'd0);
    // The unused class encoding is ignored by events and reads back as empty.
    push_trace(cslm_pkg::REQ_DISABLE, 2'd2, 2'd3,                    64'd10, 64'd11);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd2, 2'd3,                    64'd90, 64'd12);
    push_trace(cslm_pkg::REQ_READ,    2'd2, 2'd3,                    64'd0, 64'd0);
    // An interrupt start recorded at time zero still counts as no start.
    push_trace(cslm_pkg::REQ_DISABLE, 2'd2, cslm_pkg::CLASS_IRQ,     64'd0, 64'h1234);
    push_trace(cslm_pkg::REQ_ENABLE,  2'd2, cslm_pkg::CLASS_IRQ,     64'd77, 64'h5678);
    push_trace(cslm_pkg::REQ_READ,    2'd2, cslm_pkg::CLASS_IRQ,     64'd0, 64'd0);
    push_trace(cslm_pkg::REQ_CLEAR,   2'd0, cslm_pkg::CLASS_IRQ,     64'd0, 64'd0);
    push_trace(cslm_pkg::REQ_READ,    2'd1, cslm_pkg::CLASS_SOFTIRQ, 64'd0, 64'd0);
    push_trace(cslm_pkg::REQ_READ,    2'd0, cslm_pkg::CLASS_IRQ,     64'd0, 64'd0);
    settle();

    // Calm phase: zero offset, no idling on either side.
    apb_write({cslm_pkg::REG_CALIBRATION, 2'b00}, '0);
    apb_check_offset();
    phase = 1;
    calm  = 1'b1;
    add_random_traces(150);
    settle();
    calm = 1'b0;

    // Pressure phase: a random offset while the receiver holds off for a long stretch.
    apb_write({cslm_pkg::REG_CALIBRATION, 2'b00},
              cslm_pkg::CFG_DATA_W'($urandom_range(65535)));
    apb_check_offset();
    phase = 2;
    add_random_traces(150);
    settle();

    // A write to the unused register must leave the offset alone, and only the low bits
    // of a write to the offset register are kept.
    apb_write({cslm_pkg::REG_UNUSED, 2'b00}, $urandom);
    apb_check_offset();
    apb_write({cslm_pkg::REG_CALIBRATION, 2'b00},
              {16'($urandom_range(1, 65535)), 16'h0001});
    apb_check_offset();
    phase = 3;
    add_random_traces(250);
    settle();

    $display("Run covered %0d events with %0d sections measured and %0d reads checked,",
             n_items, n_measured, n_reads);
    $display("under offsets 0, 65535 and random ones, a calm phase and a long output hold-off.");
    if (errors == 0) begin
      $display("** critical_section_latency_monitor: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** critical_section_latency_monitor: FAILED **");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d events queued and %0d results owed",
             trace_q.size(), stats_due.size());
    $display("** critical_section_latency_monitor: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
design/cslm_pkg.sv
design/cslm_if.sv
design/critical_section_latency_monitor.sv
tb/sv/critical_section_latency_monitor_test.sv
